FILE: sv/assert_macros.svh
// Assertion macros for the RTL of the touch report tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

FILE: sv/trt_pkg.sv
// Types, constants and helper functions of the touch report tracker.
package trt_pkg;

    localparam int NUM_POINTS = 5;
    localparam int IDX_W      = 3;

    typedef logic [15:0] t_coord;
    typedef logic [7:0]  t_byte;

    typedef enum logic [1:0] {
        CFG_ORIENTATION   = 2'd0,
        CFG_SCREEN_WIDTH  = 2'd1,
        CFG_SCREEN_HEIGHT = 2'd2,
        CFG_MIRROR_SPAN   = 2'd3
    } t_cfg_reg;

    localparam t_coord RST_SCREEN_WIDTH  = 16'd800;
    localparam t_coord RST_SCREEN_HEIGHT = 16'd480;
    localparam t_coord RST_MIRROR_SPAN   = 16'd800;
    localparam t_coord COORD_CLEARED     = 16'hFFFF;

    localparam t_byte FLAG_PRESSED  = 8'h80;
    localparam t_byte FLAG_CAUGHT   = 8'h40;
    localparam t_byte STATUS_READY  = 8'h80;
    localparam t_byte IDLE_MASK     = 8'h8F;
    localparam t_byte IDLE_CODE     = 8'h80;
    localparam t_byte IDLE_KEEP     = 8'hE0;
    localparam t_byte POLL_EVERY    = 8'd10;
    localparam t_byte POLL_WRAP_AT  = 8'd240;
    localparam t_byte POLL_WRAP_TO  = 8'd10;

    // True when the value is a multiple of the poll interval.
    function automatic logic is_poll_multiple(input t_byte value);
        logic hit;
        hit = 1'b0;
        for (int k = 0; k * POLL_EVERY < 256; k++) begin
            hit = hit | (value == 8'(k * POLL_EVERY));
        end
        return hit;
    endfunction

    // Mask with the lowest count bits set.
    function automatic logic [NUM_POINTS-1:0] count_mask(input logic [3:0] count);
        logic [NUM_POINTS-1:0] m;
        for (int i = 0; i < NUM_POINTS; i++) begin
            m[i] = (4'(i) < count);
        end
        return m;
    endfunction

endpackage

FILE: sv/touch_report_tracker.sv
// Top level of the touch report tracker: state update and serial point results.
//
// One input beat is one scan call: caller mode, status byte and raw words of
// five points. The call is decoded in the cycle it is accepted and the new
// point store, flags and poll counter are registered at that edge. The block
// then sends five result beats, one per stored point, starting the cycle after
// acceptance; the fifth beat carries last_point.
// The single result channel sends one point a beat, so a new call waits until
// the five result beats of the call in hand have been sent.
// The next call is accepted in the same cycle as the fifth result beat is
// taken, so calls follow each other without a gap.
// While the receiver stalls, the current result beat holds and the input side
// stalls once the call in hand is fully decoded.
// Reset clears the poll counter, the flags and the point store, and loads the
// configuration registers with their defaults. Configuration is written over
// the APB-style port with zero wait states.
module touch_report_tracker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [7:0]           i_caller_mode,
    input  logic [7:0]           i_touch_status,
    input  logic [15:0]          i_pt0_first_word,
    input  logic [15:0]          i_pt0_second_word,
    input  logic [15:0]          i_pt1_first_word,
    input  logic [15:0]          i_pt1_second_word,
    input  logic [15:0]          i_pt2_first_word,
    input  logic [15:0]          i_pt2_second_word,
    input  logic [15:0]          i_pt3_first_word,
    input  logic [15:0]          i_pt3_second_word,
    input  logic [15:0]          i_pt4_first_word,
    input  logic [15:0]          i_pt4_second_word,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [2:0]           o_point_index,
    output logic [15:0]          o_point_x,
    output logic [15:0]          o_point_y,
    output logic [7:0]           o_touch_flags,
    output logic                 o_touched,
    output logic                 o_clear_status,
    output logic                 o_last_point
);
    import trt_pkg::*;
`include "assert_macros.svh"

    localparam int BK = NUM_POINTS - 1;

    logic             r_orientation;
    t_coord           r_screen_width;
    t_coord           r_screen_height;
    t_coord           r_mirror_span;

    t_byte            r_poll;
    t_byte            r_flags;
    t_coord           r_x [NUM_POINTS];
    t_coord           r_y [NUM_POINTS];
    logic             r_touched;
    logic             r_clr;
    logic             r_out_valid;
    logic [IDX_W-1:0] r_beat;

    t_byte            n_poll;
    t_byte            n_flags;
    t_coord           n_x [NUM_POINTS];
    t_coord           n_y [NUM_POINTS];
    logic             n_touched;
    logic             n_clr;

    t_coord           w1 [NUM_POINTS];
    t_coord           w2 [NUM_POINTS];
    t_byte            poll_inc;
    t_byte            mode;
    logic             polled;
    logic [3:0]       count;
    logic [NUM_POINTS-1:0] mask;
    logic             off_screen;

    logic             in_acc;
    logic             out_acc;
    logic             last_beat;
    logic             cfg_wr;

    assign w1[0] = i_pt0_first_word;
    assign w2[0] = i_pt0_second_word;
    assign w1[1] = i_pt1_first_word;
    assign w2[1] = i_pt1_second_word;
    assign w1[2] = i_pt2_first_word;
    assign w2[2] = i_pt2_second_word;
    assign w1[3] = i_pt3_first_word;
    assign w2[3] = i_pt3_second_word;
    assign w1[4] = i_pt4_first_word;
    assign w2[4] = i_pt4_second_word;

    assign last_beat  = (r_beat == IDX_W'(NUM_POINTS - 1));
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_out_valid && !(out_acc && last_beat);
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        poll_inc   = r_poll + 8'd1;
        polled     = (poll_inc < POLL_EVERY) || is_poll_multiple(poll_inc);
        mode       = polled ? i_touch_status : i_caller_mode;
        count      = mode[3:0];
        mask       = count_mask(count);
        n_clr      = polled && ((mode & STATUS_READY) != 8'd0)
                     && (count <= 4'(NUM_POINTS));
        n_touched  = polled && (count >= 4'd1) && (count <= 4'(NUM_POINTS));
        n_poll     = poll_inc;
        n_flags    = r_flags;
        off_screen = 1'b0;
        for (int i = 0; i < NUM_POINTS; i++) begin
            n_x[i] = r_x[i];
            n_y[i] = r_y[i];
        end
        if (n_touched) begin
            n_flags = FLAG_PRESSED | FLAG_CAUGHT | 8'(mask);
            n_x[BK] = r_x[0];
            n_y[BK] = r_y[0];
            for (int i = 0; i < NUM_POINTS; i++) begin
                if (mask[i]) begin
                    if (!r_orientation) begin
                        n_y[i] = w1[i];
                        n_x[i] = r_mirror_span - w2[i];
                    end else begin
                        n_x[i] = w1[i];
                        n_y[i] = w2[i];
                    end
                end
            end
            off_screen = (n_x[0] > r_screen_width) || (n_y[0] > r_screen_height);
            if (off_screen) begin
                if (count > 4'd1 && NUM_POINTS > 1) begin
                    n_x[0] = n_x[1 % NUM_POINTS];
                    n_y[0] = n_y[1 % NUM_POINTS];
                    n_poll = 8'd0;
                end else begin
                    n_x[0]  = n_x[BK];
                    n_y[0]  = n_y[BK];
                    mode    = IDLE_CODE;
                    n_flags = r_flags;
                end
            end else begin
                n_poll = 8'd0;
            end
        end
        if ((mode & IDLE_MASK) == IDLE_CODE) begin
            if ((n_flags & FLAG_PRESSED) != 8'd0) begin
                n_flags = n_flags & ~FLAG_PRESSED;
            end else begin
                n_x[0]  = COORD_CLEARED;
                n_y[0]  = COORD_CLEARED;
                n_flags = n_flags & IDLE_KEEP;
            end
        end
        if (n_poll > POLL_WRAP_AT) begin
            n_poll = POLL_WRAP_TO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll      <= 8'd0;
            r_flags     <= 8'd0;
            r_touched   <= 1'b0;
            r_clr       <= 1'b0;
            r_out_valid <= 1'b0;
            r_beat      <= '0;
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_x[i] <= '0;
                r_y[i] <= '0;
            end
        end else if (in_acc) begin
            r_poll      <= n_poll;
            r_flags     <= n_flags;
            r_touched   <= n_touched;
            r_clr       <= n_clr;
            r_out_valid <= 1'b1;
            r_beat      <= '0;
            for (int i = 0; i < NUM_POINTS; i++) begin
                r_x[i] <= n_x[i];
                r_y[i] <= n_y[i];
            end
        end else if (out_acc) begin
            if (last_beat) begin
                r_out_valid <= 1'b0;
            end else begin
                r_beat <= r_beat + IDX_W'(1);
            end
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation   <= 1'b0;
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_mirror_span   <= RST_MIRROR_SPAN;
        end else if (cfg_wr) begin
            unique case (t_cfg_reg'(paddr[3:2]))
                CFG_ORIENTATION:   r_orientation   <= pwdata[0];
                CFG_SCREEN_WIDTH:  r_screen_width  <= pwdata[15:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= pwdata[15:0];
                CFG_MIRROR_SPAN:   r_mirror_span   <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (t_cfg_reg'(paddr[3:2]))
            CFG_ORIENTATION:   prdata = {31'd0, r_orientation};
            CFG_SCREEN_WIDTH:  prdata = {16'd0, r_screen_width};
            CFG_SCREEN_HEIGHT: prdata = {16'd0, r_screen_height};
            CFG_MIRROR_SPAN:   prdata = {16'd0, r_mirror_span};
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_point_index  = r_beat;
    assign o_point_x      = r_x[r_beat];
    assign o_point_y      = r_y[r_beat];
    assign o_touch_flags  = r_flags;
    assign o_touched      = r_touched;
    assign o_clear_status = r_clr;
    assign o_last_point   = last_beat;

    `ASSERT_PROP(a_accept_starts_call, i_clk, i_rst_n, in_acc |=> (r_out_valid && r_beat == '0))
    `ASSERT_PROP(a_beat_in_range, i_clk, i_rst_n, r_beat <= IDX_W'(NUM_POINTS - 1))
    `ASSERT_PROP(a_beat_advances, i_clk, i_rst_n,
                 (out_acc && !last_beat) |=> (r_beat == $past(r_beat) + IDX_W'(1)))
    `ASSERT_PROP(a_call_ends, i_clk, i_rst_n,
                 (out_acc && last_beat && !in_acc) |=> !r_out_valid)
    `ASSERT_NEVER(a_no_mid_call_accept, i_clk, i_rst_n, in_acc && r_out_valid && !last_beat)

endmodule
